// ===== rtl/tkls_pkg.sv =====
`timescale 1ns / 1ps
package tkls_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int D2_W    = 50;
	localparam int DIST_W  = 25;
	localparam int RAD_W   = 20;
	localparam int SCORE_W = 32;
	localparam int NUM_W   = 36;
	localparam int IDX_W   = 8;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT,
		ST_DIV,
		ST_INS,
		ST_EMIT
	} state_t;

	// Register addresses in words
	localparam logic [1:0] REG_VIEW_X = 2'd0;
	localparam logic [1:0] REG_VIEW_Y = 2'd1;
	localparam logic [1:0] REG_VIEW_Z = 2'd2;

endpackage

// ===== rtl/tkls_score.sv =====
`timescale 1ns / 1ps
// Iterative score unit: three squares through one multiplier, a two-bit-a-step
// integer root, then a one-bit-a-step restoring divide with saturation.
module tkls_score (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_x,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_y,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_z,
	input  logic signed [tkls_pkg::COORD_W-1:0] view_x,
	input  logic signed [tkls_pkg::COORD_W-1:0] view_y,
	input  logic signed [tkls_pkg::COORD_W-1:0] view_z,
	input  logic        [tkls_pkg::RAD_W-1:0]   radius,
	output logic                                done,
	output logic        [tkls_pkg::SCORE_W-1:0] score
);

	localparam int PH_W = 3;
	localparam int DIFF_W = tkls_pkg::DIFF_W;
	typedef enum logic [PH_W-1:0] {
		PH_IDLE, PH_SQR, PH_ROOT, PH_DIV, PH_FIN
	} phase_t;

	phase_t                          phase_q;
	logic [5:0]                      cnt_q;
	logic [tkls_pkg::DIFF_W-1:0]     ax_q, ay_q, az_q;
	logic [tkls_pkg::D2_W-1:0]       acc_q;
	logic [tkls_pkg::D2_W+1:0]       rem_q;
	logic [tkls_pkg::DIST_W-1:0]     root_q;
	logic [tkls_pkg::NUM_W-1:0]      num_q;
	logic [tkls_pkg::DIST_W:0]       drem_q;
	logic [tkls_pkg::NUM_W-1:0]      quo_q;

	logic signed [tkls_pkg::DIFF_W-1:0] dx, dy, dz;
	logic [tkls_pkg::DIFF_W-1:0]     mul_a;
	logic [tkls_pkg::D2_W-1:0]       prod;
	logic [tkls_pkg::D2_W+1:0]       trial;
	logic [tkls_pkg::D2_W+1:0]       rem_sh;
	logic [tkls_pkg::DIST_W+1:0]     dtrial;

	assign dx = DIFF_W'(pos_x) - DIFF_W'(view_x);
	assign dy = DIFF_W'(pos_y) - DIFF_W'(view_y);
	assign dz = DIFF_W'(pos_z) - DIFF_W'(view_z);

	// Pick the axis for the shared multiplier
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mul_a = ax_q;
			2'd1:    mul_a = ay_q;
			default: mul_a = az_q;
		endcase
	end
	assign prod = tkls_pkg::D2_W'(mul_a) * tkls_pkg::D2_W'(mul_a);

	// Root step: bring down two bits of the radicand
	assign rem_sh = {rem_q[tkls_pkg::D2_W-1:0],
		acc_q[tkls_pkg::D2_W-1 -: 2]};
	assign trial  = {rem_q[tkls_pkg::D2_W-1:0], acc_q[tkls_pkg::D2_W-1 -: 2]}
		- {25'd0, root_q, 2'b01};

	// Divide step: bring down one numerator bit
	assign dtrial = {drem_q, num_q[tkls_pkg::NUM_W-1]} - {2'b00, root_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: if (start) begin
					phase_q <= PH_SQR;
					cnt_q   <= '0;
				end
				PH_SQR: if (cnt_q == 6'd2) begin
					phase_q <= PH_ROOT;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
				PH_ROOT: if (cnt_q == 6'd24) begin
					phase_q <= PH_DIV;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
				PH_DIV: if (cnt_q == 6'(tkls_pkg::NUM_W - 1) || root_q == '0) begin
					phase_q <= PH_FIN;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
				PH_FIN:  phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				ax_q  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
				ay_q  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
				az_q  <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
				acc_q <= '0;
				num_q <= {radius, 16'd0};
			end
			PH_SQR: begin
				acc_q  <= acc_q + prod;
				rem_q  <= '0;
				root_q <= '0;
			end
			PH_ROOT: begin
				acc_q <= {acc_q[tkls_pkg::D2_W-3:0], 2'b00};
				if (!trial[tkls_pkg::D2_W+1]) begin
					rem_q  <= trial;
					root_q <= {root_q[tkls_pkg::DIST_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[tkls_pkg::DIST_W-2:0], 1'b0};
				end
				drem_q <= '0;
				quo_q  <= '0;
			end
			PH_DIV: begin
				num_q <= {num_q[tkls_pkg::NUM_W-2:0], 1'b0};
				if (!dtrial[tkls_pkg::DIST_W+1]) begin
					drem_q <= dtrial[tkls_pkg::DIST_W:0];
					quo_q  <= {quo_q[tkls_pkg::NUM_W-2:0], 1'b1};
				end else begin
					drem_q <= {drem_q[tkls_pkg::DIST_W-1:0], num_q[tkls_pkg::NUM_W-1]};
					quo_q  <= {quo_q[tkls_pkg::NUM_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done  = (phase_q == PH_FIN);
	assign score = (root_q == '0 || quo_q[tkls_pkg::NUM_W-1:tkls_pkg::SCORE_W] != '0)
		? tkls_pkg::SCORE_MAX : quo_q[tkls_pkg::SCORE_W-1:0];

endmodule

// ===== rtl/top_k_light_selector_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Signals                                            | Direction
// ----------+----------------------------------------------------+----------
// light in  | in_valid, in_stall, light_index, pos_*, radius,    | in
//           | last_light                                         |
// chosen out| out_valid, out_stall, chosen_index, last_chosen    | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready| APB
//
// A light passes through the shared score unit (squares, root steps, divide steps
// and a finish step; the divide ends early at a zero distance), then through
// insertion (one kept entry shifted per cycle) and an idle state, where the next
// word is taken. On the last light, one word per cycle is emitted while out_stall
// is low. in_stall stays high while busy.
// Reset clears the frame count and the view origin; the kept list needs none.
module top_k_light_selector_unit #(
	parameter int KEEP_COUNT = 32,
	parameter int MAX_LIGHTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic        [tkls_pkg::IDX_W-1:0]   light_index,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_x,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_y,
	input  logic signed [tkls_pkg::COORD_W-1:0] pos_z,
	input  logic        [tkls_pkg::RAD_W-1:0]   radius,
	input  logic                                last_light,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [tkls_pkg::IDX_W-1:0]   chosen_index,
	output logic                                last_chosen,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [3:0]                   paddr,
	input  logic        [31:0]                  pwdata,
	output logic        [31:0]                  prdata,
	output logic                                pready
);

	localparam int KW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam int CW = $clog2(MAX_LIGHTS + 1);

	tkls_pkg::state_t state_q, state_d;

	logic signed [tkls_pkg::COORD_W-1:0] view_x_q, view_y_q, view_z_q;
	logic [CW-1:0]                 count_q;
	logic [tkls_pkg::IDX_W-1:0]    idx_q;
	logic                          last_q;
	logic [tkls_pkg::SCORE_W-1:0]  score_q;
	logic [KW:0]                   held_q;
	logic [KW:0]                   ptr_q;
	logic [KW:0]                   emit_q;
	logic [KW:0]                   total_q;
	logic                          arrival_q;

	logic [tkls_pkg::IDX_W-1:0]    ent_idx_q [KEEP_COUNT];
	logic [tkls_pkg::SCORE_W-1:0]  ent_score_q [KEEP_COUNT];
	logic [tkls_pkg::IDX_W-1:0]    arr_idx_q [KEEP_COUNT];

	logic in_acc, out_acc, score_done, cfg_wr;
	logic [tkls_pkg::SCORE_W-1:0] new_score;
	logic [KW-1:0] pm1;
	logic shift_here;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// Configuration writes and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			view_z_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tkls_pkg::REG_VIEW_X: view_x_q <= pwdata[tkls_pkg::COORD_W-1:0];
				tkls_pkg::REG_VIEW_Y: view_y_q <= pwdata[tkls_pkg::COORD_W-1:0];
				tkls_pkg::REG_VIEW_Z: view_z_q <= pwdata[tkls_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tkls_pkg::REG_VIEW_X: prdata = {{8{view_x_q[23]}}, view_x_q};
			tkls_pkg::REG_VIEW_Y: prdata = {{8{view_y_q[23]}}, view_y_q};
			tkls_pkg::REG_VIEW_Z: prdata = {{8{view_z_q[23]}}, view_z_q};
			default:              prdata = '0;
		endcase
	end

	tkls_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && count_q < CW'(MAX_LIGHTS)),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.view_x (view_x_q),
		.view_y (view_y_q),
		.view_z (view_z_q),
		.radius (radius),
		.done   (score_done),
		.score  (new_score)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tkls_pkg::ST_IDLE: if (in_acc) begin
				if (count_q < CW'(MAX_LIGHTS))
					state_d = tkls_pkg::ST_SQR;
				else if (last_light)
					state_d = tkls_pkg::ST_EMIT;
			end
			tkls_pkg::ST_SQR: if (score_done) state_d = tkls_pkg::ST_INS;
			tkls_pkg::ST_INS: begin
				if (held_q == (KW+1)'(KEEP_COUNT) &&
					score_q <= ent_score_q[KEEP_COUNT-1])
					state_d = last_q ? tkls_pkg::ST_EMIT : tkls_pkg::ST_IDLE;
				else if (ptr_q == '0 || ent_score_q[pm1] >= score_q)
					state_d = last_q ? tkls_pkg::ST_EMIT : tkls_pkg::ST_IDLE;
			end
			tkls_pkg::ST_EMIT: if (total_q == '0 ||
				(out_acc && emit_q + 1'b1 == total_q))
				state_d = tkls_pkg::ST_IDLE;
			default: state_d = tkls_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall  = (state_q != tkls_pkg::ST_IDLE);
		out_valid = (state_q == tkls_pkg::ST_EMIT) && total_q != '0;
		chosen_index = arrival_q ? arr_idx_q[emit_q[KW-1:0]] : ent_idx_q[emit_q[KW-1:0]];
		last_chosen  = (emit_q + 1'b1 == total_q);
	end

	assign pm1 = KW'(ptr_q - 1'b1);
	assign shift_here = !(ptr_q == '0 || ent_score_q[pm1] >= score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkls_pkg::ST_IDLE;
			count_q <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tkls_pkg::ST_IDLE && in_acc && count_q < CW'(MAX_LIGHTS))
				count_q <= count_q + 1'b1;
			if (state_q == tkls_pkg::ST_INS && state_d != tkls_pkg::ST_INS &&
				held_q < (KW+1)'(KEEP_COUNT) )
				held_q <= held_q + 1'b1;
			if (state_q == tkls_pkg::ST_EMIT && state_d == tkls_pkg::ST_IDLE) begin
				count_q <= '0;
				held_q  <= '0;
			end
		end
	end

	// Capture the light, walk the insertion point down, emit
	always_ff @(posedge clk) begin
		if (state_q == tkls_pkg::ST_IDLE && in_acc) begin
			idx_q  <= light_index;
			last_q <= last_light;
			emit_q <= '0;
			if (count_q < CW'(KEEP_COUNT))
				arr_idx_q[count_q[KW-1:0]] <= light_index;
			if (count_q >= CW'(MAX_LIGHTS)) begin
				total_q   <= held_q;
				arrival_q <= (count_q <= CW'(KEEP_COUNT));
			end
		end
		if (state_q == tkls_pkg::ST_SQR) begin
			score_q <= new_score;
			ptr_q   <= (held_q == (KW+1)'(KEEP_COUNT)) ? (KW+1)'(KEEP_COUNT - 1) : held_q;
		end
		if (state_q == tkls_pkg::ST_INS) begin
			if (!(held_q == (KW+1)'(KEEP_COUNT) && score_q <= ent_score_q[KEEP_COUNT-1])) begin
				if (shift_here) begin
					ent_idx_q[ptr_q[KW-1:0]]   <= ent_idx_q[pm1];
					ent_score_q[ptr_q[KW-1:0]] <= ent_score_q[pm1];
					ptr_q <= ptr_q - 1'b1;
				end else begin
					ent_idx_q[ptr_q[KW-1:0]]   <= idx_q;
					ent_score_q[ptr_q[KW-1:0]] <= score_q;
				end
			end
			if (state_d == tkls_pkg::ST_EMIT) begin
				total_q   <= (held_q < (KW+1)'(KEEP_COUNT)) ? held_q + 1'b1 : held_q;
				arrival_q <= (count_q <= CW'(KEEP_COUNT));
			end
		end
		if (state_q == tkls_pkg::ST_EMIT && out_acc)
			emit_q <= emit_q + 1'b1;
	end

`ifndef SYNTHESIS
	a_no_out_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("output while input open");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= (KW+1)'(KEEP_COUNT)) else $error("kept count overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LIGHTS)) else $error("light count overflow");
`endif

endmodule
